// ----- src/midi_track_byte_parser_defines.svh -----
// Assertion macros for the MIDI track byte parser top level.
`ifndef MIDI_TRACK_BYTE_PARSER_DEFINES_SVH
`define MIDI_TRACK_BYTE_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MTP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("parser check failed");

// Next-cycle implication, checked outside reset.
`define MTP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("parser check failed");

`endif

// ----- src/mtp_pkg.sv -----
// Types, codes and small tables for the MIDI track byte parser.
package mtp_pkg;

  // Input beat kinds.
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // Result event kinds.
  localparam logic [2:0] EV_CHANNEL  = 3'd0;
  localparam logic [2:0] EV_TEMPO    = 3'd1;
  localparam logic [2:0] EV_TIME_SIG = 3'd2;
  localparam logic [2:0] EV_TITLE    = 3'd3;
  localparam logic [2:0] EV_END      = 3'd4;
  localparam logic [2:0] EV_BAD_TAG  = 3'd5;
  localparam logic [2:0] EV_TRUNC    = 3'd6;

  // Status and meta type bytes of interest.
  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
  localparam logic [7:0] META_TEMPO   = 8'h51;
  localparam logic [7:0] META_END     = 8'h2F;
  localparam logic [7:0] META_TITLE   = 8'h03;
  localparam logic [7:0] META_TIME    = 8'h58;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } mtp_beat_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [31:0] delta_time;
    logic [7:0]  status;
    logic [7:0]  data_one;
    logic [7:0]  data_two;
    logic [1:0]  data_count;
    logic [23:0] tempo;
    logic [7:0]  numerator;
    logic [7:0]  denominator_exponent;
    logic [7:0]  title_char;
    logic        title_last;
  } mtp_result_t;

  // Expected chunk tag "MTrk", one byte per position.
  function automatic logic [7:0] mtp_tag_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h4D;
      2'd1:    b = 8'h54;
      2'd2:    b = 8'h72;
      default: b = 8'h6B;
    endcase
    return b;
  endfunction

  // Data bytes that follow a status byte, indexed by status bits 6..4.
  function automatic logic [1:0] mtp_data_need(input logic [2:0] hi);
    logic [1:0] n;
    case (hi)
      3'd4, 3'd5: n = 2'd1;
      3'd7:       n = 2'd0;
      default:    n = 2'd2;
    endcase
    return n;
  endfunction

endpackage

// ----- src/mtp_in_stage.sv -----
// Input register stage: holds one incoming beat until the parser core takes it.
module mtp_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  mtp_pkg::mtp_beat_t s_beat_i,
  output logic               valid_o,
  output mtp_pkg::mtp_beat_t beat_o,
  input  logic               take_i
);
  import mtp_pkg::*;

  logic      valid_q, valid_d;
  mtp_beat_t beat_q;

  assign s_ready_o = !valid_q || take_i;
  assign valid_d   = s_ready_o ? s_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      beat_q <= s_beat_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// ----- src/mtp_core.sv -----
// Parser state machine: one beat per cycle, while no result is held back by the output, into a registered result.
module mtp_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  mtp_pkg::mtp_beat_t   beat_i,
  output logic                 take_o,
  output logic                 out_valid_o,
  output mtp_pkg::mtp_result_t result_o,
  input  logic                 out_ready_i
);
  import mtp_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE, PH_TAG, PH_LEN, PH_DELTA, PH_STATUS, PH_CHDATA, PH_MTYPE,
    PH_TEMPO_LEN, PH_TEMPO, PH_END_LEN, PH_TS_LEN, PH_TS_NUM, PH_TS_DEN,
    PH_TS_TAIL, PH_TITLE_LEN, PH_TITLE, PH_SKIP_LEN, PH_SKIP
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  bidx_q, bidx_d;
  logic [31:0] remain_q, remain_d;
  logic [31:0] vlq_q, vlq_d;
  logic [31:0] delta_q, delta_d;
  logic [7:0]  run_st_q, run_st_d;
  logic [7:0]  first_q, first_d;
  logic [23:0] tempo_q, tempo_d;
  logic [7:0]  num_q, num_d;
  logic        tag_ok_q, tag_ok_d;
  logic        out_valid_q, out_valid_d;
  mtp_result_t result_q, result_d;
  logic        emit;

  assign take_o = in_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    logic [7:0]  b;
    logic [31:0] vlq_next;
    logic [31:0] rem_dec;
    logic [7:0]  rs_eff;
    logic [1:0]  bi_new;
    logic [1:0]  need;
    logic        tag_now;
    b        = beat_i.data_byte;
    vlq_next = {vlq_q[24:0], b[6:0]};
    rem_dec  = remain_q - 32'd1;
    rs_eff   = b[7] ? b : run_st_q;
    bi_new   = b[7] ? 2'd0 : 2'd1;
    need     = mtp_data_need(rs_eff[6:4]);
    tag_now  = tag_ok_q && (b == mtp_tag_byte(bidx_q));

    phase_d  = phase_q;
    bidx_d   = bidx_q;
    remain_d = remain_q;
    vlq_d    = vlq_q;
    delta_d  = delta_q;
    run_st_d = run_st_q;
    first_d  = first_q;
    tempo_d  = tempo_q;
    num_d    = num_q;
    tag_ok_d = tag_ok_q;
    emit     = 1'b0;
    result_d = '0;

    if (beat_i.kind == KIND_DATA && phase_q != PH_IDLE) begin
      unique case (phase_q)
        PH_TAG: begin
          if (!tag_now) begin
            tag_ok_d = 1'b0;
          end
          if (bidx_q == 2'd3) begin
            bidx_d = 2'd0;
            if (!tag_now) begin
              phase_d             = PH_IDLE;
              emit                = 1'b1;
              result_d.event_kind = EV_BAD_TAG;
            end else begin
              phase_d = PH_LEN;
            end
          end else begin
            bidx_d = bidx_q + 2'd1;
          end
        end
        PH_LEN: begin
          if (bidx_q == 2'd3) begin
            bidx_d  = 2'd0;
            phase_d = PH_DELTA;
            vlq_d   = '0;
          end else begin
            bidx_d = bidx_q + 2'd1;
          end
        end
        PH_DELTA: begin
          vlq_d = vlq_next;
          if (!b[7]) begin
            delta_d = vlq_next;
            phase_d = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (b == ST_META) begin
            phase_d = PH_MTYPE;
          end else if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
            phase_d = PH_SKIP_LEN;
            vlq_d   = '0;
          end else begin
            run_st_d = rs_eff;
            bidx_d   = bi_new;
            if (!b[7]) begin
              first_d = b;
            end
            if (bi_new >= need) begin
              emit                = 1'b1;
              result_d.event_kind = EV_CHANNEL;
              result_d.delta_time = delta_q;
              result_d.status     = rs_eff;
              if (bi_new == 2'd1) begin
                result_d.data_one   = b;
                result_d.data_count = 2'd1;
              end
              phase_d = PH_DELTA;
              vlq_d   = '0;
            end else begin
              remain_d = {30'd0, need};
              phase_d  = PH_CHDATA;
            end
          end
        end
        PH_CHDATA: begin
          if (bidx_q == 2'd0) begin
            first_d = b;
            bidx_d  = 2'd1;
            if (remain_q <= 32'd1) begin
              emit                = 1'b1;
              result_d.event_kind = EV_CHANNEL;
              result_d.delta_time = delta_q;
              result_d.status     = run_st_q;
              result_d.data_one   = b;
              result_d.data_count = 2'd1;
              phase_d             = PH_DELTA;
              vlq_d               = '0;
            end
          end else begin
            emit                = 1'b1;
            result_d.event_kind = EV_CHANNEL;
            result_d.delta_time = delta_q;
            result_d.status     = run_st_q;
            result_d.data_one   = first_q;
            result_d.data_two   = b;
            result_d.data_count = 2'd2;
            phase_d             = PH_DELTA;
            vlq_d               = '0;
          end
        end
        PH_MTYPE: begin
          vlq_d = '0;
          if (b == META_TEMPO) begin
            phase_d = PH_TEMPO_LEN;
          end else if (b == META_END) begin
            phase_d = PH_END_LEN;
          end else if (b == META_TITLE) begin
            phase_d = PH_TITLE_LEN;
          end else if (b == META_TIME) begin
            phase_d = PH_TS_LEN;
          end else begin
            phase_d = PH_SKIP_LEN;
          end
        end
        PH_TEMPO_LEN: begin
          phase_d = PH_TEMPO;
          bidx_d  = 2'd0;
          tempo_d = '0;
        end
        PH_TEMPO: begin
          tempo_d = {tempo_q[15:0], b};
          if (bidx_q >= 2'd2) begin
            bidx_d              = 2'd0;
            emit                = 1'b1;
            result_d.event_kind = EV_TEMPO;
            result_d.delta_time = delta_q;
            result_d.tempo      = {tempo_q[15:0], b};
            phase_d             = PH_DELTA;
            vlq_d               = '0;
          end else begin
            bidx_d = bidx_q + 2'd1;
          end
        end
        PH_END_LEN: begin
          phase_d             = PH_IDLE;
          emit                = 1'b1;
          result_d.event_kind = EV_END;
          result_d.delta_time = delta_q;
        end
        PH_TS_LEN: begin
          phase_d = PH_TS_NUM;
        end
        PH_TS_NUM: begin
          num_d   = b;
          phase_d = PH_TS_DEN;
        end
        PH_TS_DEN: begin
          emit                          = 1'b1;
          result_d.event_kind           = EV_TIME_SIG;
          result_d.delta_time           = delta_q;
          result_d.numerator            = num_q;
          result_d.denominator_exponent = b;
          phase_d                       = PH_TS_TAIL;
          bidx_d                        = 2'd0;
        end
        PH_TS_TAIL: begin
          if (bidx_q >= 2'd1) begin
            bidx_d  = 2'd0;
            phase_d = PH_DELTA;
            vlq_d   = '0;
          end else begin
            bidx_d = bidx_q + 2'd1;
          end
        end
        PH_TITLE_LEN, PH_SKIP_LEN: begin
          vlq_d = vlq_next;
          if (!b[7]) begin
            remain_d = vlq_next;
            if (vlq_next == 32'd0) begin
              phase_d = PH_DELTA;
              vlq_d   = '0;
            end else begin
              phase_d = (phase_q == PH_TITLE_LEN) ? PH_TITLE : PH_SKIP;
            end
          end
        end
        PH_TITLE: begin
          remain_d            = rem_dec;
          emit                = 1'b1;
          result_d.event_kind = EV_TITLE;
          result_d.delta_time = delta_q;
          result_d.title_char = b;
          result_d.title_last = (rem_dec == 32'd0);
          if (rem_dec == 32'd0) begin
            phase_d = PH_DELTA;
            vlq_d   = '0;
          end
        end
        PH_SKIP: begin
          remain_d = rem_dec;
          if (rem_dec == 32'd0) begin
            phase_d = PH_DELTA;
            vlq_d   = '0;
          end
        end
        default: begin
        end
      endcase
    end else if (beat_i.kind == KIND_START) begin
      if (phase_q != PH_IDLE) begin
        emit                = 1'b1;
        result_d.event_kind = EV_TRUNC;
      end
      phase_d  = PH_TAG;
      bidx_d   = 2'd0;
      tag_ok_d = 1'b1;
    end else if (beat_i.kind == KIND_END && phase_q != PH_IDLE) begin
      phase_d             = PH_IDLE;
      bidx_d              = 2'd0;
      emit                = 1'b1;
      result_d.event_kind = EV_TRUNC;
    end
  end

  always_comb begin
    if (take_o) begin
      out_valid_d = emit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bidx_q      <= '0;
      remain_q    <= '0;
      vlq_q       <= '0;
      delta_q     <= '0;
      run_st_q    <= '0;
      first_q     <= '0;
      tempo_q     <= '0;
      num_q       <= '0;
      tag_ok_q    <= 1'b1;
      out_valid_q <= 1'b0;
      result_q    <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take_o) begin
        phase_q  <= phase_d;
        bidx_q   <= bidx_d;
        remain_q <= remain_d;
        vlq_q    <= vlq_d;
        delta_q  <= delta_d;
        run_st_q <= run_st_d;
        first_q  <= first_d;
        tempo_q  <= tempo_d;
        num_q    <= num_d;
        tag_ok_q <= tag_ok_d;
        if (emit) begin
          result_q <= result_d;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

// ----- src/midi_track_byte_parser.sv -----
// Top level of the MIDI track byte parser: input stage, parser core and port packing.
//
//   Channel   Dir  tdata                                          tuser       tlast
//   s_axis    in   data_byte[7:0]                                 kind[1:0]   -
//   m_axis    out  delta_time, status, data_one, data_two,        event_kind  title_last
//                  data_count, tempo, numerator,
//                  denominator_exponent, title_char (112 bits)
//
// One beat is taken every cycle when the output side keeps up; each beat is a single
// state transition of the parser core, so nothing iterates.
// An input beat passes through the input register and then the result register before
// its result appears.
// Backpressure on m_axis holds the result register; the input register still takes one
// more beat, after which s_axis_tready_o drops until the result leaves.
// Reset is asynchronous and active low; it puts the parser in its idle state with the
// running status cleared. Beats that produce no result leave the result data untouched.
`include "midi_track_byte_parser_defines.svh"

module midi_track_byte_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] data_byte
  input  logic [1:0]   s_axis_tuser_i,   // [1:0] kind
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [31:0] delta_time, [39:32] status, [47:40] data_one, [55:48] data_two,
  // [57:56] data_count, [81:58] tempo, [89:82] numerator,
  // [97:90] denominator_exponent, [105:98] title_char, [111:106] zero
  output logic [111:0] m_axis_tdata_o,
  output logic [2:0]   m_axis_tuser_o,   // [2:0] event_kind
  output logic         m_axis_tlast_o    // title_last
);
  import mtp_pkg::*;

  mtp_beat_t   s_beat;
  mtp_beat_t   core_beat;
  logic        core_valid;
  logic        core_take;
  mtp_result_t res;

  assign s_beat.kind      = s_axis_tuser_i;
  assign s_beat.data_byte = s_axis_tdata_i;

  // Input register: lets the source deliver one more beat while the result register is stalled.
  mtp_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_beat_i  (s_beat),
    .valid_o   (core_valid),
    .beat_o    (core_beat),
    .take_i    (core_take)
  );

  // Parser core: holds all track state and the registered result beat.
  mtp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (core_valid),
    .beat_i      (core_beat),
    .take_o      (core_take),
    .out_valid_o (m_axis_tvalid_o),
    .result_o    (res),
    .out_ready_i (m_axis_tready_i)
  );

  // Fields not meaningful for an event kind are already zero in the result.
  assign m_axis_tdata_o = {6'd0, res.title_char, res.denominator_exponent, res.numerator,
                           res.tempo, res.data_count, res.data_two, res.data_one,
                           res.status, res.delta_time};
  assign m_axis_tuser_o = res.event_kind;
  assign m_axis_tlast_o = res.title_last;

  // The last-character flag only ever rides on a title character.
  `MTP_ASSERT_NOW(a_last_only_title, m_axis_tvalid_o && res.title_last,
                  res.event_kind == EV_TITLE)
  // Error results carry no delta time.
  `MTP_ASSERT_NOW(a_error_no_delta,
                  m_axis_tvalid_o && (res.event_kind == EV_BAD_TAG ||
                  res.event_kind == EV_TRUNC), res.delta_time == 32'd0)
  // A channel event never reports more than two data bytes.
  `MTP_ASSERT_NOW(a_chan_count, m_axis_tvalid_o && res.event_kind == EV_CHANNEL,
                  res.data_count != 2'd3)
  // With no result waiting, a held input beat is always taken by the core at once.
  `MTP_ASSERT_NOW(a_free_core_takes, core_valid && !m_axis_tvalid_o, core_take)

endmodule
